// ----- design/nne_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package nne_pkg;

  localparam int LABEL_DEPTH = 32;
  localparam int LEN_W       = $clog2(LABEL_DEPTH + 1);
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PAD_CHAR    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUFFIX_BYTE = 1'd1;

  localparam logic [7:0] PAD_RESET    = 8'h20;
  localparam logic [7:0] SUFFIX_RESET = 8'h00;
  localparam logic [7:0] NAME_HDR     = 8'h20;
  localparam logic [7:0] LETTER_A     = 8'h41;
  localparam logic [7:0] DOT_CHAR     = 8'h2E;
  localparam logic [7:0] TERM_BYTE    = 8'h00;
  localparam logic [3:0] NAME_LEN     = 4'd15;

  typedef struct packed {
    logic             push;
    logic             shift;
    logic [LEN_W-1:0] idx;
  } lbl_ctl_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    upcase = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  function automatic logic [7:0] letter(input logic [3:0] nib);
    letter = LETTER_A + {4'h0, nib};
  endfunction

endpackage
`default_nettype wire

// ----- design/nne_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface nne_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       part;
  logic       has_char;
  logic       part_end;

  modport source (output valid, char_byte, part, has_char, part_end, input ready);
  modport sink   (input valid, char_byte, part, has_char, part_end, output ready);
endinterface
`default_nettype wire

// ----- design/nne_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface nne_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

// ----- design/nne_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface nne_cfg_if;
  import nne_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [7:0]           wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

// ----- design/nne_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nne_cell (
  input  wire logic       clk,
  input  wire logic       wr_en,
  input  wire logic [7:0] wr_data,
  input  wire logic       shift_en,
  input  wire logic [7:0] shift_in,
  output logic      [7:0] data
);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      data <= wr_data;
    end else if (shift_en) begin
      data <= shift_in;
    end
  end

endmodule
`default_nettype wire

// ----- design/nne_label_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nne_label_chain (
  input  wire logic              clk,
  input  wire nne_pkg::lbl_ctl_t ctl,
  input  wire logic [7:0]        wr_data,
  output logic      [7:0]        head
);
  import nne_pkg::*;

  logic [7:0] cell_data [LABEL_DEPTH];

  for (genvar i = 0; i < LABEL_DEPTH; i++) begin : g_cell
    logic [7:0] nb;
    if (i == LABEL_DEPTH - 1) begin : g_end
      assign nb = cell_data[i];
    end else begin : g_mid
      assign nb = cell_data[i+1];
    end
    nne_cell u_cell (
      .clk      (clk),
      .wr_en    (ctl.push && (ctl.idx == LEN_W'(i))),
      .wr_data  (wr_data),
      .shift_en (ctl.shift),
      .shift_in (nb),
      .data     (cell_data[i])
    );
  end

  assign head = cell_data[0];

endmodule
`default_nettype wire

// ----- design/netbios_name_encoder_core.sv -----
// NetBIOS second-level name encoder.
// din takes one word per character: char_byte, part (0 name, 1 scope),
// has_char and part_end. dout gives the encoded byte stream, last marking
// the terminating zero. cfg writes pad_char (index 0) and suffix_byte
// (index 1); it is always ready and should only be written while idle.
// One word is worked on at a time: din is ready only when the sequencer is
// idle, and each produced byte passes through the output register. A name
// character produces two letters; closing the name emits the padding and
// suffix pairs, two bytes per character. A scope label is held in a chain of
// cells and, on a '.' or part end, shifted out to the head cell one byte per
// cycle while dout is not stalled. Words that produce no bytes are taken every
// cycle. After a word that produces bytes is accepted, the sequencer enters
// its first emit state, and that byte is registered before it is valid on dout.
// When dout stalls, the output register holds its byte and the sequencer
// waits; nothing is dropped. Reset (rst, synchronous) returns to idle,
// clears the name and scope state and restores pad 0x20 and suffix 0x00.
// Label contents need no clearing; only written cells are read.
`timescale 1ns / 1ps
`default_nettype none
module netbios_name_encoder_core (
  input  wire logic  clk,
  input  wire logic  rst,
  nne_in_if.sink     din,
  nne_out_if.source  dout,
  nne_cfg_if.sink    cfg
);
  import nne_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_HDR     = 11'b00000000010,
    S_CHAR_HI = 11'b00000000100,
    S_CHAR_LO = 11'b00000001000,
    S_PAD_HI  = 11'b00000010000,
    S_PAD_LO  = 11'b00000100000,
    S_SUF_HI  = 11'b00001000000,
    S_SUF_LO  = 11'b00010000000,
    S_LEN     = 11'b00100000000,
    S_BODY    = 11'b01000000000,
    S_TERM    = 11'b10000000000
  } state_t;

  state_t           state, state_next;
  logic [7:0]       pad_char, suffix_byte;
  logic             header_sent, header_sent_next;
  logic             name_closed, name_closed_next;
  logic [3:0]       name_count, name_count_next;
  logic [LEN_W-1:0] label_length, label_length_next;
  logic             scope_seen, scope_seen_next;
  logic             do_char, do_char_next;
  logic             do_close, do_close_next;
  logic             do_term, do_term_next;
  logic [7:0]       char_up, char_up_next;
  logic             obuf_valid, obuf_valid_next;
  logic [7:0]       obuf_byte, obuf_byte_next;
  logic             obuf_last, obuf_last_next;

  logic             emit_ok, emit, emit_last, flush_go;
  logic [7:0]       emit_byte, head;
  logic [3:0]       name_count_inc;
  lbl_ctl_t         lbl_ctl;

  assign emit_ok        = !obuf_valid || dout.ready;
  assign name_count_inc = name_count + 4'd1;
  assign din.ready      = (state == S_IDLE);
  assign cfg.ready      = 1'b1;
  assign dout.valid     = obuf_valid;
  assign dout.out_byte  = obuf_byte;
  assign dout.last      = obuf_last;

  nne_label_chain u_chain (
    .clk     (clk),
    .ctl     (lbl_ctl),
    .wr_data (upcase(din.char_byte)),
    .head    (head)
  );

  always_comb begin
    state_next        = state;
    header_sent_next  = header_sent;
    name_closed_next  = name_closed;
    name_count_next   = name_count;
    label_length_next = label_length;
    scope_seen_next   = scope_seen;
    do_char_next      = do_char;
    do_close_next     = do_close;
    do_term_next      = do_term;
    char_up_next      = char_up;
    emit              = 1'b0;
    emit_byte         = TERM_BYTE;
    emit_last         = 1'b0;
    flush_go          = 1'b0;
    lbl_ctl.push      = 1'b0;
    lbl_ctl.shift     = 1'b0;
    lbl_ctl.idx       = label_length;

    unique case (state)
      S_IDLE: begin
        if (din.valid) begin
          if (!din.part) begin
            if (!name_closed) begin
              header_sent_next = 1'b1;
              do_char_next     = din.has_char && (name_count < NAME_LEN);
              do_close_next    = din.part_end;
              char_up_next     = upcase(din.char_byte);
              if (!header_sent) begin
                state_next = S_HDR;
              end else if (din.has_char && (name_count < NAME_LEN)) begin
                state_next = S_CHAR_HI;
              end else if (din.part_end) begin
                state_next = (name_count < NAME_LEN) ? S_PAD_HI : S_SUF_HI;
              end
            end
          end else if (!name_closed) begin
            header_sent_next = 1'b1;
            do_char_next     = 1'b0;
            do_close_next    = 1'b1;
            if (!header_sent) begin
              state_next = S_HDR;
            end else begin
              state_next = (name_count < NAME_LEN) ? S_PAD_HI : S_SUF_HI;
            end
          end else begin
            do_term_next = din.part_end;
            if (din.has_char) begin
              scope_seen_next = 1'b1;
              if (din.char_byte == DOT_CHAR) begin
                flush_go = 1'b1;
              end else begin
                if (label_length < LEN_W'(LABEL_DEPTH)) begin
                  lbl_ctl.push      = 1'b1;
                  label_length_next = label_length + LEN_W'(1);
                end
                flush_go = din.part_end;
              end
            end else begin
              flush_go = din.part_end && scope_seen;
            end
            if (flush_go) begin
              state_next = S_LEN;
            end else if (din.part_end) begin
              state_next = S_TERM;
            end
          end
        end
      end
      S_HDR: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_byte = NAME_HDR;
          if (do_char) begin
            state_next = S_CHAR_HI;
          end else if (do_close) begin
            state_next = (name_count < NAME_LEN) ? S_PAD_HI : S_SUF_HI;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_CHAR_HI: begin
        if (emit_ok) begin
          emit       = 1'b1;
          emit_byte  = letter(char_up[7:4]);
          state_next = S_CHAR_LO;
        end
      end
      S_CHAR_LO: begin
        if (emit_ok) begin
          emit            = 1'b1;
          emit_byte       = letter(char_up[3:0]);
          name_count_next = name_count_inc;
          if (do_close) begin
            state_next = (name_count_inc < NAME_LEN) ? S_PAD_HI : S_SUF_HI;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_PAD_HI: begin
        if (emit_ok) begin
          emit       = 1'b1;
          emit_byte  = letter(pad_char[7:4]);
          state_next = S_PAD_LO;
        end
      end
      S_PAD_LO: begin
        if (emit_ok) begin
          emit            = 1'b1;
          emit_byte       = letter(pad_char[3:0]);
          name_count_next = name_count_inc;
          state_next      = (name_count_inc < NAME_LEN) ? S_PAD_HI : S_SUF_HI;
        end
      end
      S_SUF_HI: begin
        if (emit_ok) begin
          emit       = 1'b1;
          emit_byte  = letter(suffix_byte[7:4]);
          state_next = S_SUF_LO;
        end
      end
      S_SUF_LO: begin
        if (emit_ok) begin
          emit             = 1'b1;
          emit_byte        = letter(suffix_byte[3:0]);
          name_closed_next = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_LEN: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_byte = {{(8-LEN_W){1'b0}}, label_length};
          if (label_length != '0) begin
            state_next = S_BODY;
          end else begin
            state_next = do_term ? S_TERM : S_IDLE;
          end
        end
      end
      S_BODY: begin
        if (emit_ok) begin
          emit              = 1'b1;
          emit_byte         = head;
          lbl_ctl.shift     = 1'b1;
          label_length_next = label_length - LEN_W'(1);
          if (label_length == LEN_W'(1)) begin
            state_next = do_term ? S_TERM : S_IDLE;
          end
        end
      end
      S_TERM: begin
        if (emit_ok) begin
          emit              = 1'b1;
          emit_byte         = TERM_BYTE;
          emit_last         = 1'b1;
          name_count_next   = '0;
          header_sent_next  = 1'b0;
          name_closed_next  = 1'b0;
          label_length_next = '0;
          scope_seen_next   = 1'b0;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    obuf_byte_next  = obuf_byte;
    obuf_last_next  = obuf_last;
    obuf_valid_next = obuf_valid && !dout.ready;
    if (emit) begin
      obuf_valid_next = 1'b1;
      obuf_byte_next  = emit_byte;
      obuf_last_next  = emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pad_char     <= PAD_RESET;
      suffix_byte  <= SUFFIX_RESET;
      header_sent  <= 1'b0;
      name_closed  <= 1'b0;
      name_count   <= '0;
      label_length <= '0;
      scope_seen   <= 1'b0;
      do_char      <= 1'b0;
      do_close     <= 1'b0;
      do_term      <= 1'b0;
      obuf_valid   <= 1'b0;
    end else begin
      state        <= state_next;
      header_sent  <= header_sent_next;
      name_closed  <= name_closed_next;
      name_count   <= name_count_next;
      label_length <= label_length_next;
      scope_seen   <= scope_seen_next;
      do_char      <= do_char_next;
      do_close     <= do_close_next;
      do_term      <= do_term_next;
      obuf_valid   <= obuf_valid_next;
      if (cfg.valid) begin
        unique case (cfg.reg_index)
          REG_PAD_CHAR:    pad_char    <= cfg.wr_data;
          REG_SUFFIX_BYTE: suffix_byte <= cfg.wr_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    char_up   <= char_up_next;
    obuf_byte <= obuf_byte_next;
    obuf_last <= obuf_last_next;
  end

  a_label_bound: assert property (@(posedge clk) disable iff (rst)
    label_length <= LEN_W'(LABEL_DEPTH))
    else $error("label length past buffer depth");

  a_name_bound: assert property (@(posedge clk) disable iff (rst)
    name_count <= NAME_LEN)
    else $error("name count past fifteen");

  a_last_zero: assert property (@(posedge clk) disable iff (rst)
    obuf_valid && obuf_last |-> obuf_byte == TERM_BYTE)
    else $error("last word is not the terminating zero");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_TERM) && emit_ok |=> !header_sent && !name_closed && !scope_seen
      && (state == S_IDLE))
    else $error("state not cleared after terminating zero");

  a_body_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_BODY |-> label_length != '0)
    else $error("label body with empty label");

endmodule
`default_nettype wire

// ----- verif/nne_stream_checker.sv -----
`timescale 1ns / 1ps
module nne_stream_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    in_char,
  input  logic                          in_part,
  input  logic                          in_has,
  input  logic                          in_end,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [7:0]                    out_byte,
  input  logic                          out_last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [nne_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output int                            errors,
  output int                            pending
);
  import nne_pkg::*;

  // {last, byte}
  logic [8:0] expected_bytes[$];
  logic [8:0] want;
  logic [7:0] pad;
  logic [7:0] suffix;
  logic [3:0] name_cnt;
  logic       hdr_sent;
  logic       name_done;
  logic       scope_any;
  logic [7:0] label_buf[LABEL_DEPTH];
  int         label_len;
  int         err_cnt;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic lst);
    expected_bytes.push_back({lst, b});
  endtask

  task automatic push_pair(input logic [7:0] c);
    push_byte(LETTER_A + {4'h0, c[7:4]}, 1'b0);
    push_byte(LETTER_A + {4'h0, c[3:0]}, 1'b0);
  endtask

  task automatic send_header();
    if (!hdr_sent) begin
      push_byte(NAME_HDR, 1'b0);
      hdr_sent = 1'b1;
    end
  endtask

  task automatic close_name();
    for (int i = int'(name_cnt); i < int'(NAME_LEN); i++) push_pair(pad);
    push_pair(suffix);
    name_done = 1'b1;
  endtask

  task automatic flush_label();
    push_byte(label_len[7:0], 1'b0);
    for (int i = 0; i < label_len; i++) push_byte(label_buf[i], 1'b0);
    label_len = 0;
  endtask

  task automatic clear_state();
    name_cnt  = '0;
    hdr_sent  = 1'b0;
    name_done = 1'b0;
    scope_any = 1'b0;
    label_len = 0;
  endtask

  task automatic encode_word(input logic [7:0] c, input logic prt, input logic has,
                             input logic fin);
    if (!prt) begin
      if (!name_done) begin
        send_header();
        if (has && name_cnt < NAME_LEN) begin
          push_pair(to_upper(c));
          name_cnt++;
        end
        if (fin) close_name();
      end
    end else if (!name_done) begin
      // scope word on an open name only closes it
      send_header();
      close_name();
    end else begin
      if (has) begin
        scope_any = 1'b1;
        if (c == DOT_CHAR) flush_label();
        else if (label_len < LABEL_DEPTH) begin
          label_buf[label_len] = to_upper(c);
          label_len++;
        end
      end
      if (fin) begin
        if (scope_any && !(has && c == DOT_CHAR)) flush_label();
        push_byte(TERM_BYTE, 1'b1);
        clear_state();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      pad     = PAD_RESET;
      suffix  = SUFFIX_RESET;
      err_cnt = 0;
      expected_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected word: byte %h last %b", out_byte, out_last);
        end else begin
          want = expected_bytes.pop_front();
          if (want !== {out_last, out_byte}) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected byte %h last %b, got byte %h last %b",
                       want[7:0], want[8], out_byte, out_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PAD_CHAR:    pad = cfg_data;
          REG_SUFFIX_BYTE: suffix = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) encode_word(in_char, in_part, in_has, in_end);
    end
    errors  <= err_cnt;
    pending <= expected_bytes.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import nne_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   pending;
  int   words_sent = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;

  nne_in_if  din_if ();
  nne_out_if dout_if ();
  nne_cfg_if cfg_if ();

  netbios_name_encoder_core uut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if),
    .cfg  (cfg_if)
  );

  nne_stream_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din_if.valid),
    .in_ready  (din_if.ready),
    .in_char   (din_if.char_byte),
    .in_part   (din_if.part),
    .in_has    (din_if.has_char),
    .in_end    (din_if.part_end),
    .out_valid (dout_if.valid),
    .out_ready (dout_if.ready),
    .out_byte  (dout_if.out_byte),
    .out_last  (dout_if.last),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .cfg_index (cfg_if.reg_index),
    .cfg_data  (cfg_if.wr_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #4 clk = ~clk;

  initial begin
    dout_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      dout_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("netbios_name_encoder_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic [7:0] c, input logic prt, input logic has,
                      input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid     <= 1'b1;
    din_if.char_byte <= c;
    din_if.part      <= prt;
    din_if.has_char  <= has;
    din_if.part_end  <= fin;
    do @(posedge clk); while (!din_if.ready);
    words_sent++;
  endtask

  task automatic wait_idle();
    din_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_char(input bit allow_dot);
    logic [7:0] c;
    int         r;
    r = $urandom_range(99);
    if (r < 50) c = 8'h61 + 8'($urandom_range(25));
    else if (r < 70) c = 8'h41 + 8'($urandom_range(25));
    else c = 8'($urandom_range(255));
    if (!allow_dot && c == DOT_CHAR) c = 8'h2D;
    return c;
  endfunction

  task automatic run_name();
    int nlen;
    int nlab;
    int llen;
    int r;
    nlen = ($urandom_range(99) < 15) ? $urandom_range(16, 20) : $urandom_range(15);
    for (int i = 0; i < nlen; i++) begin
      if ($urandom_range(9) == 0) send(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
      send(rand_char(1), 1'b0, 1'b1, 1'b0);
    end
    r = $urandom_range(99);
    if (r < 65) send(rand_char(1), 1'b0, 1'b1, 1'b1);
    else if (r < 80) send(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1);
    else send(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)),
              1'($urandom_range(1)));
    // name words after close are dropped
    if ($urandom_range(9) == 0)
      send(rand_char(1), 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
    if ($urandom_range(99) < 20) begin
      send(8'($urandom_range(255)), 1'b1, 1'b0, 1'b1);
    end else begin
      nlab = $urandom_range(1, 3);
      for (int l = 0; l < nlab; l++) begin
        llen = ($urandom_range(99) < 6) ? $urandom_range(33, 36) : $urandom_range(6);
        for (int j = 0; j < llen; j++) begin
          if ($urandom_range(19) == 0) send(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0);
          send(rand_char(0), 1'b1, 1'b1, 1'b0);
        end
        if (l < nlab - 1) send(DOT_CHAR, 1'b1, 1'b1, 1'b0);
      end
      r = $urandom_range(99);
      if (r < 30) send(DOT_CHAR, 1'b1, 1'b1, 1'b1);
      else if (r < 70) send(rand_char(0), 1'b1, 1'b1, 1'b1);
      else send(8'($urandom_range(255)), 1'b1, 1'b0, 1'b1);
    end
  endtask

  initial begin
    rst              <= 1'b1;
    din_if.valid     <= 1'b0;
    din_if.char_byte <= '0;
    din_if.part      <= 1'b0;
    din_if.has_char  <= 1'b0;
    din_if.part_end  <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= REG_PAD_CHAR;
    cfg_if.wr_data   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // case boundaries, byte extremes, dropped name word, empty labels, dot on end
    send(8'h61, 1'b0, 1'b1, 1'b0);
    send(8'h7A, 1'b0, 1'b1, 1'b0);
    send(8'h60, 1'b0, 1'b1, 1'b0);
    send(8'h7B, 1'b0, 1'b1, 1'b0);
    send(8'hFF, 1'b0, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b0, 1'b1);
    send(8'h71, 1'b0, 1'b1, 1'b0);
    send(DOT_CHAR, 1'b1, 1'b1, 1'b0);
    send(DOT_CHAR, 1'b1, 1'b1, 1'b0);
    send(8'h78, 1'b1, 1'b1, 1'b0);
    send(8'h59, 1'b1, 1'b1, 1'b0);
    send(DOT_CHAR, 1'b1, 1'b1, 1'b1);
    // scope word closes an open name, then empty scope
    send(8'h6B, 1'b1, 1'b1, 1'b0);
    send(8'hFF, 1'b1, 1'b0, 1'b1);
    // one-char name, label ended by a bare end word
    send(8'h4D, 1'b0, 1'b1, 1'b1);
    send(8'h61, 1'b1, 1'b1, 1'b0);
    send(8'h62, 1'b1, 1'b1, 1'b0);
    send(8'h00, 1'b1, 1'b0, 1'b1);
    // all-pad name, label closed by its last char
    send(8'h00, 1'b0, 1'b0, 1'b1);
    send(8'h63, 1'b1, 1'b1, 1'b1);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(REG_PAD_CHAR, 8'h00);
          write_reg(REG_SUFFIX_BYTE, 8'hFF);
          idle_pct = 0;  stall_pct = 0;
        end
        1: begin
          write_reg(REG_PAD_CHAR, 8'hFF);
          write_reg(REG_SUFFIX_BYTE, 8'h00);
          idle_pct = 72; stall_pct = 0;
        end
        2: begin
          write_reg(REG_PAD_CHAR, 8'($urandom_range(255)));
          write_reg(REG_SUFFIX_BYTE, 8'($urandom_range(255)));
          idle_pct = 0;  stall_pct = 72;
        end
        default: begin
          write_reg(REG_PAD_CHAR, 8'($urandom_range(255)));
          write_reg(REG_SUFFIX_BYTE, 8'($urandom_range(255)));
          idle_pct = 27; stall_pct = 27;
        end
      endcase
      while (words_sent < 21 + 73 * (p + 1)) run_name();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("netbios_name_encoder_core test passed");
    end else begin
      $display("netbios_name_encoder_core test failed");
    end
    $finish;
  end

endmodule
